// ===== rtl/core/lfu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and structs of the LFU cache policy block.
package lfu_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int UCNT_W  = 32;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
    localparam logic [VAL_W-1:0]  NO_VALUE  = 32'hFFFF_FFFF;
    localparam logic [UCNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [UCNT_W-1:0] COUNT_ONE = 32'd1;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t        req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } res_t;

    typedef struct packed {
        logic             ready;
        logic             done;
        logic [CNT_W-1:0] occupancy;
    } stat_t;

endpackage

// ===== rtl/core/lfu_cache_policy_top.sv =====
`timescale 1ns / 1ps
// Top level of the LFU cache policy block: stream ports, capacity register, output register.
// Each accepted word runs a match/victim scan over the entries, then a recency rank pass when an
// entry is touched or filled (a get miss or an ignored put skips it), then waits for the output.
// One word is taken at a time: a new word is accepted only after the result of the last has been
// loaded into the output register.
// Reset clears the valid bits and the occupancy, sets the capacity to 64, leaves memories as is.
module lfu_cache_policy_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // key [31:0], value [63:32]
    input  logic [63:0]                s_tdata,
    // req_type [0]
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_value [31:0], evicted_key [63:32]
    output logic [63:0]                m_tdata,
    // hit [0], evicted [1]
    output logic [1:0]                 m_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]  cfg_data
);

    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    logic [lfu_pkg::CNT_W-1:0] cap_eff;
    logic                      m_tvalid_reg;
    logic [63:0]               m_tdata_reg;
    logic [1:0]                m_tuser_reg;
    logic                      out_free;
    lfu_pkg::req_t             in_req;
    lfu_pkg::stat_t            stat;
    lfu_pkg::res_t             res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    always_comb begin
        if (32'(cap_reg) > 32'(lfu_pkg::ENTRIES)) begin
            cap_eff = lfu_pkg::CNT_W'(lfu_pkg::ENTRIES);
        end else begin
            cap_eff = lfu_pkg::CNT_W'(cap_reg);
        end
    end

    assign in_req.req_type = lfu_pkg::req_type_t'(s_tuser[0]);
    assign in_req.key      = s_tdata[31:0];
    assign in_req.value    = s_tdata[63:32];
    assign out_free        = !m_tvalid_reg || m_tready;
    assign s_tready        = stat.ready;

    lfu_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_req   (in_req),
        .cap      (cap_eff),
        .out_free (out_free),
        .stat     (stat),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (stat.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (stat.done) begin
            m_tdata_reg <= {res.evicted_key, res.read_value};
            m_tuser_reg <= {res.evicted, res.hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_evict_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("evicting result also reports a hit");

    a_evict_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[31:0] == lfu_pkg::NO_VALUE))
        else $error("evicting result carries a read value");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an accepted word");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(stat.occupancy) <= 32'(lfu_pkg::ENTRIES))
        else $error("occupancy above entry count");
`endif

endmodule

// ===== rtl/core/lfu_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM with one write port and one registered read port.
module lfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lfu_engine.sv =====
`timescale 1ns / 1ps
// Sequencer that scans the entry memories, picks the slot and updates recency ranks.
module lfu_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  lfu_pkg::req_t             in_req,
    input  logic [lfu_pkg::CNT_W-1:0] cap,
    input  logic                      out_free,
    output lfu_pkg::stat_t            stat,
    output lfu_pkg::res_t             res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPD,
        ST_DONE
    } state_t;

    localparam logic [lfu_pkg::CNT_W-1:0] LAST_IDX = lfu_pkg::CNT_W'(lfu_pkg::ENTRIES);

    state_t                          state_reg;
    lfu_pkg::req_t                   req_reg;
    logic [lfu_pkg::CNT_W-1:0]       idx_reg;
    logic                            act_reg;
    logic [lfu_pkg::IDX_W-1:0]       aidx_reg;
    logic                            found_reg;
    logic [lfu_pkg::IDX_W-1:0]       m_slot_reg;
    logic [lfu_pkg::UCNT_W-1:0]      m_cnt_reg;
    logic [lfu_pkg::IDX_W-1:0]       m_rank_reg;
    logic [lfu_pkg::VAL_W-1:0]       m_val_reg;
    logic                            free_found_reg;
    logic [lfu_pkg::IDX_W-1:0]       free_slot_reg;
    logic                            vic_found_reg;
    logic [lfu_pkg::IDX_W-1:0]       vic_slot_reg;
    logic [lfu_pkg::UCNT_W-1:0]      vic_cnt_reg;
    logic [lfu_pkg::IDX_W-1:0]       vic_rank_reg;
    logic [lfu_pkg::KEY_W-1:0]       vic_key_reg;
    logic [lfu_pkg::IDX_W-1:0]       s_reg;
    logic [lfu_pkg::CNT_W-1:0]       r_reg;
    logic [lfu_pkg::ENTRIES-1:0]     valid_reg;
    logic [lfu_pkg::CNT_W-1:0]       occ_reg;
    lfu_pkg::res_t                   res_reg;

    logic [lfu_pkg::KEY_W-1:0]       key_rd;
    logic [lfu_pkg::VAL_W-1:0]       val_rd;
    logic [lfu_pkg::UCNT_W-1:0]      cnt_rd;
    logic [lfu_pkg::IDX_W-1:0]       rank_rd;
    logic [lfu_pkg::IDX_W-1:0]       raddr;

    logic                            v_cur;
    logic                            key_eq;
    logic                            better_vic;
    logic                            rank_we;
    logic [lfu_pkg::IDX_W-1:0]       rank_wdata;
    logic                            ent_we;
    logic                            kv_we;

    logic                            dec_upd;
    logic                            dec_free;
    logic [lfu_pkg::IDX_W-1:0]       dec_s;
    logic [lfu_pkg::CNT_W-1:0]       dec_r;
    logic [lfu_pkg::UCNT_W-1:0]      dec_cnt;
    lfu_pkg::res_t                   dec_res;

    assign raddr  = idx_reg[lfu_pkg::IDX_W-1:0];
    assign v_cur  = valid_reg[aidx_reg];
    assign key_eq = (key_rd == req_reg.key);
    assign better_vic = !vic_found_reg || (cnt_rd < vic_cnt_reg) ||
                        ((cnt_rd == vic_cnt_reg) && (rank_rd > vic_rank_reg));

    assign rank_we = (state_reg == ST_UPD) && act_reg &&
                     ((aidx_reg == s_reg) ||
                      (v_cur && (lfu_pkg::CNT_W'(rank_rd) < r_reg)));
    assign rank_wdata = (aidx_reg == s_reg) ? '0 : rank_rd + lfu_pkg::IDX_W'(1);
    assign ent_we = (state_reg == ST_DECIDE) && dec_upd;
    assign kv_we  = ent_we && (req_reg.req_type == lfu_pkg::REQ_PUT);

    always_comb begin
        dec_upd  = 1'b0;
        dec_free = 1'b0;
        dec_s    = m_slot_reg;
        dec_r    = lfu_pkg::CNT_W'(m_rank_reg);
        dec_cnt  = (m_cnt_reg == lfu_pkg::COUNT_MAX) ? m_cnt_reg
                                                     : m_cnt_reg + lfu_pkg::COUNT_ONE;
        dec_res.hit         = 1'b0;
        dec_res.read_value  = lfu_pkg::NO_VALUE;
        dec_res.evicted     = 1'b0;
        dec_res.evicted_key = '0;
        if (req_reg.req_type == lfu_pkg::REQ_GET) begin
            if (found_reg) begin
                dec_upd            = 1'b1;
                dec_res.hit        = 1'b1;
                dec_res.read_value = m_val_reg;
            end
        end else if (cap != '0) begin
            if (found_reg) begin
                dec_upd     = 1'b1;
                dec_res.hit = 1'b1;
            end else if (occ_reg < cap) begin
                dec_upd  = 1'b1;
                dec_free = 1'b1;
                dec_s    = free_slot_reg;
                dec_r    = LAST_IDX;
                dec_cnt  = lfu_pkg::COUNT_ONE;
            end else if (vic_found_reg) begin
                dec_upd             = 1'b1;
                dec_s               = vic_slot_reg;
                dec_r               = lfu_pkg::CNT_W'(vic_rank_reg);
                dec_cnt             = lfu_pkg::COUNT_ONE;
                dec_res.evicted     = 1'b1;
                dec_res.evicted_key = vic_key_reg;
            end
        end
    end

    lfu_ram #(.WIDTH(lfu_pkg::KEY_W), .DEPTH(lfu_pkg::ENTRIES)) u_key_ram (
        .aclk(aclk), .we(kv_we), .waddr(dec_s), .wdata(req_reg.key),
        .raddr(raddr), .rdata(key_rd)
    );

    lfu_ram #(.WIDTH(lfu_pkg::VAL_W), .DEPTH(lfu_pkg::ENTRIES)) u_val_ram (
        .aclk(aclk), .we(kv_we), .waddr(dec_s), .wdata(req_reg.value),
        .raddr(raddr), .rdata(val_rd)
    );

    lfu_ram #(.WIDTH(lfu_pkg::UCNT_W), .DEPTH(lfu_pkg::ENTRIES)) u_cnt_ram (
        .aclk(aclk), .we(ent_we), .waddr(dec_s), .wdata(dec_cnt),
        .raddr(raddr), .rdata(cnt_rd)
    );

    lfu_ram #(.WIDTH(lfu_pkg::IDX_W), .DEPTH(lfu_pkg::ENTRIES)) u_rank_ram (
        .aclk(aclk), .we(rank_we), .waddr(aidx_reg), .wdata(rank_wdata),
        .raddr(raddr), .rdata(rank_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            act_reg   <= 1'b0;
            valid_reg <= '0;
            occ_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    act_reg <= 1'b0;
                    if (in_valid) begin
                        req_reg        <= in_req;
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        vic_found_reg  <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    act_reg  <= (idx_reg < LAST_IDX);
                    aidx_reg <= idx_reg[lfu_pkg::IDX_W-1:0];
                    idx_reg  <= idx_reg + lfu_pkg::CNT_W'(1);
                    if (act_reg) begin
                        if (v_cur && key_eq && !found_reg) begin
                            found_reg  <= 1'b1;
                            m_slot_reg <= aidx_reg;
                            m_cnt_reg  <= cnt_rd;
                            m_rank_reg <= rank_rd;
                            m_val_reg  <= val_rd;
                        end
                        if (!v_cur && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_slot_reg  <= aidx_reg;
                        end
                        if (v_cur && better_vic) begin
                            vic_found_reg <= 1'b1;
                            vic_slot_reg  <= aidx_reg;
                            vic_cnt_reg   <= cnt_rd;
                            vic_rank_reg  <= rank_rd;
                            vic_key_reg   <= key_rd;
                        end
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    act_reg <= 1'b0;
                    res_reg <= dec_res;
                    s_reg   <= dec_s;
                    r_reg   <= dec_r;
                    idx_reg <= '0;
                    if (dec_upd) begin
                        valid_reg[dec_s] <= 1'b1;
                    end
                    if (dec_free) begin
                        occ_reg <= occ_reg + lfu_pkg::CNT_W'(1);
                    end
                    state_reg <= dec_upd ? ST_UPD : ST_DONE;
                end
                ST_UPD: begin
                    act_reg  <= (idx_reg < LAST_IDX);
                    aidx_reg <= idx_reg[lfu_pkg::IDX_W-1:0];
                    idx_reg  <= idx_reg + lfu_pkg::CNT_W'(1);
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    act_reg <= 1'b0;
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.ready     = (state_reg == ST_IDLE);
    assign stat.done      = (state_reg == ST_DONE) && out_free;
    assign stat.occupancy = occ_reg;
    assign res            = res_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LFU cache with predicted results, bursts and receiver stalls.
module tb_top;

    class lfu_scoreboard;
        bit                           slot_valid[lfu_pkg::ENTRIES];
        bit [lfu_pkg::KEY_W-1:0]      slot_key[lfu_pkg::ENTRIES];
        bit [lfu_pkg::VAL_W-1:0]      slot_value[lfu_pkg::ENTRIES];
        bit [lfu_pkg::UCNT_W-1:0]     slot_uses[lfu_pkg::ENTRIES];
        int unsigned                  slot_age[lfu_pkg::ENTRIES];
        int unsigned                  filled;
        bit [lfu_pkg::CAP_W-1:0]      capacity;
        lfu_pkg::res_t                expected_q[$];
        int unsigned                  errors, n_get, n_put, n_hit, n_evict, n_checked, n_cap;

        function new();
            capacity = lfu_pkg::CAP_RESET;
            filled = 0;
            foreach (slot_valid[i]) begin
                slot_valid[i] = 1'b0;
                slot_age[i] = 0;
            end
        endfunction

        function void set_capacity(bit [lfu_pkg::CAP_W-1:0] cap);
            capacity = cap;
            n_cap++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void touch_slot(int s);
            int unsigned r;
            r = slot_age[s];
            if (slot_uses[s] != lfu_pkg::COUNT_MAX) slot_uses[s]++;
            foreach (slot_valid[i]) begin
                if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
            end
            slot_age[s] = 0;
        endfunction

        function void evict_slot(int s);
            int unsigned r;
            r = slot_age[s];
            slot_valid[s] = 1'b0;
            foreach (slot_valid[i]) begin
                if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
            end
            filled--;
        endfunction

        function void fill_slot(int s, bit [lfu_pkg::KEY_W-1:0] k,
                                bit [lfu_pkg::VAL_W-1:0] v);
            foreach (slot_valid[i]) begin
                if (slot_valid[i]) slot_age[i]++;
            end
            slot_valid[s] = 1'b1;
            slot_key[s]   = k;
            slot_value[s] = v;
            slot_uses[s]  = lfu_pkg::COUNT_ONE;
            slot_age[s]   = 0;
            filled++;
        endfunction

        function void note_request(lfu_pkg::req_t rq);
            lfu_pkg::res_t want;
            int   found;
            int   victim;
            int   lim;
            want.hit         = 1'b0;
            want.read_value  = lfu_pkg::NO_VALUE;
            want.evicted     = 1'b0;
            want.evicted_key = '0;
            lim = (capacity > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(capacity);
            found = -1;
            foreach (slot_valid[i]) begin
                if (found < 0 && slot_valid[i] && slot_key[i] == rq.key) found = i;
            end
            if (rq.req_type == lfu_pkg::REQ_GET) begin
                n_get++;
                if (found >= 0) begin
                    want.hit = 1'b1;
                    touch_slot(found);
                    want.read_value = slot_value[found];
                end
            end else begin
                n_put++;
                if (lim != 0) begin
                    if (found >= 0) begin
                        want.hit = 1'b1;
                        touch_slot(found);
                        slot_value[found] = rq.value;
                    end else begin
                        victim = -1;
                        if (filled < lim) begin
                            foreach (slot_valid[i]) begin
                                if (victim < 0 && !slot_valid[i]) victim = i;
                            end
                        end
                        if (victim < 0) begin
                            foreach (slot_valid[i]) begin
                                if (slot_valid[i] && (victim < 0 ||
                                    slot_uses[i] < slot_uses[victim] ||
                                    (slot_uses[i] == slot_uses[victim] &&
                                     slot_age[i] > slot_age[victim])))
                                    victim = i;
                            end
                            if (victim >= 0) begin
                                want.evicted     = 1'b1;
                                want.evicted_key = slot_key[victim];
                                evict_slot(victim);
                            end
                        end
                        if (victim >= 0) fill_slot(victim, rq.key, rq.value);
                    end
                end
            end
            if (want.hit) n_hit++;
            if (want.evicted) n_evict++;
            expected_q.insert(expected_q.size(), want);
        endfunction

        function void check_result(lfu_pkg::res_t got);
            lfu_pkg::res_t want;
            if (expected_q.size() == 0) begin
                $error("Result word arrived with no request waiting.");
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            n_checked++;
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                errors++;
            end
            if (got.evicted !== want.evicted) begin
                $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== want.evicted_key) begin
                $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
                errors++;
            end
        endfunction
    endclass

    typedef enum {RX_OPEN, RX_CHOPPY, RX_LONG} rx_mode_t;

    logic                         aclk;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [63:0]                  s_tdata   = '0;
    logic [0:0]                   s_tuser   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [63:0]                  m_tdata;
    logic [1:0]                   m_tuser;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [lfu_pkg::CAP_W-1:0]    cfg_data  = '0;

    lfu_scoreboard sb;
    rx_mode_t      rx_mode   = RX_OPEN;
    int            mode_left = 0;
    int            hold_left = 0;

    lfu_cache_policy_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(lfu_pkg::res_t'({m_tuser[0], m_tdata[31:0],
                                                 m_tuser[1], m_tdata[63:32]}));
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(200, 1500);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_CHOPPY: m_tready <= ($urandom_range(0, 1) == 1);
                default: begin
                    if (hold_left != 0) begin
                        hold_left--;
                    end else begin
                        m_tready  <= !m_tready;
                        hold_left = m_tready ? $urandom_range(5, 40) : $urandom_range(0, 6);
                    end
                end
            endcase
        end
    end

    task automatic send_word(input lfu_pkg::req_type_t kind,
                             input logic [lfu_pkg::KEY_W-1:0] key,
                             input logic [lfu_pkg::VAL_W-1:0] value);
        lfu_pkg::req_t rq;
        rq.req_type = kind;
        rq.key      = key;
        rq.value    = value;
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(rq);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_capacity(cap);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int n, input int pool_n, input int put_pct);
        logic [lfu_pkg::KEY_W-1:0] pool[128];
        int                        burst;
        int                        gap;
        lfu_pkg::req_type_t        kind;
        logic [lfu_pkg::KEY_W-1:0] key;
        foreach (pool[i]) pool[i] = $urandom;
        burst = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            kind = ($urandom_range(0, 99) < put_pct) ? lfu_pkg::REQ_PUT : lfu_pkg::REQ_GET;
            key  = ($urandom_range(0, 19) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
            send_word(kind, key, $urandom);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 8);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                pause_sender(gap);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(lfu_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(lfu_pkg::REQ_PUT, 32'h0000_0000, 32'h0000_0000);
        send_word(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(lfu_pkg::REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(lfu_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(lfu_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lfu_pkg::REQ_PUT, 32'h0000_0000, 32'h1234_5678);
        send_word(lfu_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(lfu_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);

        write_capacity(7'd0);
        send_word(lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h0000_0000);
        send_word(lfu_pkg::REQ_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(lfu_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(lfu_pkg::REQ_GET, 32'h5555_5555, 32'h0000_0000);

        write_capacity(7'd2);
        send_word(lfu_pkg::REQ_PUT, 32'hAAAA_AAAA, 32'h0000_0001);
        send_word(lfu_pkg::REQ_PUT, 32'h5555_AAAA, 32'h0000_0002);
        send_word(lfu_pkg::REQ_GET, 32'hAAAA_AAAA, 32'h0000_0000);
        send_word(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        write_capacity(7'd127);
        run_traffic(300, 96, 60);
        write_capacity(7'd1);
        run_traffic(120, 4, 50);
        write_capacity(7'd5);
        run_traffic(200, 12, 50);
        write_capacity(7'd0);
        run_traffic(60, 16, 50);
        write_capacity(7'd64);
        run_traffic(250, 80, 70);
        write_capacity(7'd3);
        run_traffic(150, 100, 50);
        write_capacity(7'd33);
        run_traffic(200, 48, 50);
        write_capacity(7'd64);
        run_traffic(70, 72, 50);

        wait_idle();
        repeat (2 * lfu_pkg::ENTRIES + 8) @(posedge aclk);
        $display("Covered %0d requests (%0d gets, %0d puts) over %0d capacity settings.",
                 sb.n_get + sb.n_put, sb.n_get, sb.n_put, sb.n_cap);
        $display("Checked %0d result words, %0d of them hits and %0d evictions.",
                 sb.n_checked, sb.n_hit, sb.n_evict);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
